[rtl/bdar_pkg.sv]
`default_nettype none

package bdar_pkg;

  // Command codes carried on s_tuser
  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_READ_PRS  = 2'd1,
    CMD_NEXT_EVT  = 2'd2,
    CMD_CLR_FLAGS = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_REPEAT_INITIAL = 2'd1;
  localparam logic [1:0] CFG_REPEAT_NEXT    = 2'd2;

  localparam logic [7:0] DEBOUNCE_LIMIT_RST = 8'd10;
  localparam logic [7:0] REPEAT_INITIAL_RST = 8'd40;
  localparam logic [7:0] REPEAT_NEXT_RST    = 8'd20;

  localparam int unsigned RAW_W  = 16;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned DATA_W = 24;

  typedef struct packed {
    logic [7:0] debounce_limit;
    logic [7:0] repeat_initial;
    logic [7:0] repeat_next;
  } cfg_t;

  // Per-button control from the command decode
  typedef struct packed {
    logic sample_en;
    logic raw_level;
    logic clr_pressed;
    logic clr_changed;
  } cell_ctrl_t;

  // Per-button status back to the top level
  typedef struct packed {
    logic stable_q;
    logic stable_d;
    logic pressed_q;
    logic changed_q;
  } cell_stat_t;

endpackage

`default_nettype wire

[rtl/bdar_cell.sv]
`default_nettype none

module bdar_cell
  import bdar_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cfg_t       cfg_i,
  input  cell_ctrl_t ctrl_i,
  output cell_stat_t stat_o
);

  logic       stable_q, stable_d;
  logic [7:0] dbc_q, dbc_d;
  logic [7:0] rep_q, rep_d;
  logic       pressed_q, pressed_d;
  logic       changed_q, changed_d;
  logic [7:0] rep_dec;

  assign rep_dec = rep_q - 8'd1;

  always_comb begin
    stable_d  = stable_q;
    dbc_d     = dbc_q;
    rep_d     = rep_q;
    pressed_d = pressed_q;
    changed_d = changed_q;
    if (ctrl_i.sample_en) begin
      if (ctrl_i.raw_level == stable_q) begin
        dbc_d = '0;
        if (!ctrl_i.raw_level) begin
          // held: auto-repeat countdown, wraps through zero
          if (rep_dec == '0) begin
            rep_d     = cfg_i.repeat_next;
            pressed_d = 1'b1;
          end else begin
            rep_d = rep_dec;
          end
        end
      end else if (dbc_q > cfg_i.debounce_limit) begin
        dbc_d     = '0;
        changed_d = 1'b1;
        rep_d     = cfg_i.repeat_initial;
        stable_d  = ctrl_i.raw_level;
        if (!ctrl_i.raw_level) begin
          pressed_d = 1'b1;
        end
      end else begin
        dbc_d = dbc_q + 8'd1;
      end
    end
    if (ctrl_i.clr_pressed) begin
      pressed_d = 1'b0;
    end
    if (ctrl_i.clr_changed) begin
      changed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q  <= 1'b0;
      dbc_q     <= '0;
      rep_q     <= '0;
      pressed_q <= 1'b0;
      changed_q <= 1'b0;
    end else begin
      stable_q  <= stable_d;
      dbc_q     <= dbc_d;
      rep_q     <= rep_d;
      pressed_q <= pressed_d;
      changed_q <= changed_d;
    end
  end

  assign stat_o.stable_q  = stable_q;
  assign stat_o.stable_d  = stable_d;
  assign stat_o.pressed_q = pressed_q;
  assign stat_o.changed_q = changed_q;

endmodule

`default_nettype wire

[rtl/bdar_event_pick.sv]
`default_nettype none

module bdar_event_pick
  import bdar_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = 16
) (
  input  wire [BUTTON_COUNT-1:0] changed_i,
  input  wire [BUTTON_COUNT-1:0] stable_i,
  output logic [BUTTON_COUNT-1:0] grant_o,
  output logic                    found_o,
  output logic [IDX_W-1:0]        button_o,
  output logic                    is_press_o
);

  // isolate lowest set bit
  assign grant_o = changed_i & ~(changed_i - BUTTON_COUNT'(1));
  assign found_o = |changed_i;
  // press when the granted button's debounced level is low
  assign is_press_o = found_o & ~|(grant_o & stable_i);

  always_comb begin
    button_o = '0;
    for (int i = 0; i < int'(BUTTON_COUNT); i++) begin
      if (grant_o[i]) begin
        button_o = button_o | IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/multi_button_debounce_autorepeat_core.sv]
`default_nettype none
// An accepted input transaction goes through the input register, then the
//   per-button update and the result register, before its result shows on m_tvalid.
// Throughput: one transaction per cycle; the input side only stalls while a
//   result is held on an unready output.
// Reset (async, active low): all button state and flags clear, config
//   registers return to limit 10, initial repeat 40, next repeat 20.
module multi_button_debounce_autorepeat_core
  import bdar_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  // input transactions
  input  wire               s_tvalid,
  output logic              s_tready,
  input  wire [DATA_W-1:0]  s_tdata,  // [15:0] raw_levels, [19:16] button_index, rest 0
  input  wire [1:0]         s_tuser,  // [1:0] command
  // result transactions
  output logic              m_tvalid,
  input  wire               m_tready,
  output logic [DATA_W-1:0] m_tdata,  // [0] pressed_seen, [1] event_found,
                                      // [5:2] event_button, [6] event_is_press,
                                      // [22:7] debounced_levels, [23] 0
  // configuration writes
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire [1:0]         cfg_index_i,
  input  wire [7:0]         cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers, always writable
  // ---------------------------------------------------------------------------
  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEBOUNCE_LIMIT: cfg_d.debounce_limit = cfg_data_i;
        CFG_REPEAT_INITIAL: cfg_d.repeat_initial = cfg_data_i;
        CFG_REPEAT_NEXT:    cfg_d.repeat_next    = cfg_data_i;
        default:            cfg_d = cfg_q;  // unused index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_limit <= DEBOUNCE_LIMIT_RST;
      cfg_q.repeat_initial <= REPEAT_INITIAL_RST;
      cfg_q.repeat_next    <= REPEAT_NEXT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic             in_valid_q, in_valid_d;
  cmd_e             cmd_q;
  logic [RAW_W-1:0] raw_q;
  logic [IDX_W-1:0] idx_q;
  logic             advance;
  logic             s_fire;

  // stage 1 moves on when the result register is free or being drained
  assign advance  = in_valid_q && (!m_tvalid || m_tready);
  assign s_tready = !in_valid_q || advance;
  assign s_fire   = s_tvalid && s_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cmd_q <= cmd_e'(s_tuser);
      raw_q <= s_tdata[RAW_W-1:0];
      idx_q <= s_tdata[RAW_W+IDX_W-1:RAW_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Per-button cells
  // ---------------------------------------------------------------------------
  cell_ctrl_t [BUTTON_COUNT-1:0] ctrl;
  cell_stat_t [BUTTON_COUNT-1:0] stat;
  logic [BUTTON_COUNT-1:0]       changed_vec;
  logic [BUTTON_COUNT-1:0]       stable_vec;
  logic [BUTTON_COUNT-1:0]       grant;
  logic                          ev_found;
  logic [IDX_W-1:0]              ev_button;
  logic                          ev_press;

  logic do_sample, do_read, do_next, do_clear;

  assign do_sample = advance && (cmd_q == CMD_SAMPLE);
  assign do_read   = advance && (cmd_q == CMD_READ_PRS);
  assign do_next   = advance && (cmd_q == CMD_NEXT_EVT);
  assign do_clear  = advance && (cmd_q == CMD_CLR_FLAGS);

  for (genvar i = 0; i < int'(BUTTON_COUNT); i++) begin : g_cell
    if (i < int'(RAW_W)) begin : g_raw
      assign ctrl[i].raw_level   = raw_q[i];
      assign ctrl[i].clr_pressed = do_clear || (do_read && (idx_q == IDX_W'(i)));
    end else begin : g_noraw
      // buttons beyond the raw word see a released level and are never read
      assign ctrl[i].raw_level   = 1'b1;
      assign ctrl[i].clr_pressed = do_clear;
    end
    assign ctrl[i].sample_en   = do_sample;
    assign ctrl[i].clr_changed = do_clear || (do_next && grant[i]);
    assign changed_vec[i]      = stat[i].changed_q;
    assign stable_vec[i]       = stat[i].stable_q;

    bdar_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (cfg_q),
      .ctrl_i (ctrl[i]),
      .stat_o (stat[i])
    );
  end

  bdar_event_pick #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_pick (
    .changed_i  (changed_vec),
    .stable_i   (stable_vec),
    .grant_o    (grant),
    .found_o    (ev_found),
    .button_o   (ev_button),
    .is_press_o (ev_press)
  );

  // ---------------------------------------------------------------------------
  // 16-bit views: missing buttons read released, and unpressed
  // ---------------------------------------------------------------------------
  logic [RAW_W-1:0] levels_nxt;
  logic [RAW_W-1:0] pressed_pad;

  for (genvar j = 0; j < int'(RAW_W); j++) begin : g_pad
    if (j < int'(BUTTON_COUNT)) begin : g_have
      assign levels_nxt[j]  = stat[j].stable_d;
      assign pressed_pad[j] = stat[j].pressed_q;
    end else begin : g_miss
      assign levels_nxt[j]  = 1'b1;
      assign pressed_pad[j] = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              res_seen, res_found, res_press;
  logic [IDX_W-1:0]  res_button;

  assign res_seen   = do_read && pressed_pad[idx_q];
  assign res_found  = do_next && ev_found;
  assign res_button = res_found ? ev_button : '0;
  assign res_press  = res_found && ev_press;

  assign out_data_d = {1'b0, levels_nxt, res_press, res_button, res_found, res_seen};

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

[rtl/bdar_checker.sv]
`default_nettype none

module bdar_checker
  import bdar_pkg::*;
(
  input wire              clk_i,
  input wire              rst_ni,
  input wire              s_tready,
  input wire              m_tvalid,
  input wire              m_tready,
  input wire [DATA_W-1:0] m_tdata
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with output free");

  // no event: button and polarity are zero
  a_event_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tdata[1] |-> m_tdata[6:2] == 5'd0)
    else $error("event fields set without event");

  // read and event results never coincide, and the spare top bit stays zero
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && !m_tdata[DATA_W-1])
    else $error("inconsistent result word");

endmodule

bind multi_button_debounce_autorepeat_core bdar_checker u_bdar_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[dv/multi_button_debounce_autorepeat_core_tb.sv]
`timescale 1ns / 1ps

module multi_button_debounce_autorepeat_core_tb;
  import bdar_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000; // cycles with no transaction at all
  localparam int unsigned HOLD_CYCLES    = 300;  // long receiver hold-off

  // Result layout, lowest bit last: matches m_tdata[22:0]
  typedef struct packed {
    logic [15:0] levels;
    logic        is_press;
    logic [3:0]  button;
    logic        found;
    logic        seen;
  } result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_tvalid;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata;   // [15:0] raw_levels, [19:16] button_index, rest 0
  logic [1:0]        s_tuser;   // [1:0] command
  logic              m_tvalid;
  logic              m_tready;
  logic [DATA_W-1:0] m_tdata;   // [0] pressed_seen, [1] event_found, [5:2] event_button,
                                // [6] event_is_press, [22:7] debounced_levels
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i;
  logic [7:0]        cfg_data_i;

  multi_button_debounce_autorepeat_core #(
    .BUTTON_COUNT(16)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow of the debouncer state and registers
  logic [15:0] btn_stable;
  logic [7:0]  btn_debounce [16];
  logic [7:0]  btn_repeat [16];
  logic [15:0] btn_pressed;
  logic [15:0] btn_changed;
  logic [7:0]  lim_shadow;
  logic [7:0]  init_shadow;
  logic [7:0]  next_shadow;

  result_t     expected_results [$];
  result_t     want_r;
  result_t     got_r;
  int          errors;
  int unsigned quiet_cycles;
  bit          no_idle;   // both sides stop idling
  bit          hold_req;  // ask the receiver for a long hold-off

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Apply one command to the shadow state and return the result it gives
  function automatic result_t step_buttons(input cmd_e c, input logic [15:0] raw,
                                           input logic [3:0] idx);
    result_t res;
    logic    lvl;
    res = '0;
    case (c)
      CMD_SAMPLE: begin
        for (int i = 0; i < 16; i++) begin
          lvl = raw[i];
          if (lvl == btn_stable[i]) begin
            btn_debounce[i] = 8'd0;
            if (!lvl) begin
              // held pressed: auto-repeat countdown, 8-bit wrap
              btn_repeat[i] = btn_repeat[i] - 8'd1;
              if (btn_repeat[i] == 8'd0) begin
                btn_repeat[i]  = next_shadow;
                btn_pressed[i] = 1'b1;
              end
            end
          end else if (btn_debounce[i] > lim_shadow) begin
            btn_debounce[i] = 8'd0;
            btn_changed[i]  = 1'b1;
            btn_repeat[i]   = init_shadow;
            btn_stable[i]   = lvl;
            if (!lvl) btn_pressed[i] = 1'b1;
          end else begin
            btn_debounce[i] = btn_debounce[i] + 8'd1;
          end
        end
      end
      CMD_READ_PRS: begin
        res.seen         = btn_pressed[idx];
        btn_pressed[idx] = 1'b0;
      end
      CMD_NEXT_EVT: begin
        for (int i = 0; i < 16; i++) begin
          if (btn_changed[i] && !res.found) begin
            btn_changed[i] = 1'b0;
            res.found      = 1'b1;
            res.button     = 4'(i);
            res.is_press   = ~btn_stable[i];
          end
        end
      end
      CMD_CLR_FLAGS: begin
        btn_pressed = '0;
        btn_changed = '0;
      end
      default: ;
    endcase
    res.levels = btn_stable;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Receiver: random idling, plus the long hold-off on request
  initial begin : rx_ready
    int unsigned hold;
    hold     = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold     = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= 15);
      end
    end
  end

  // Result checker and watchdog; values read here are those before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got_r = result_t'(m_tdata[22:0]);
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result, expected none, actual %h", $time, m_tdata);
        end else begin
          want_r = expected_results.pop_front();
          check_field("pressed_seen", 16'(want_r.seen), 16'(got_r.seen));
          check_field("event_found", 16'(want_r.found), 16'(got_r.found));
          check_field("event_button", 16'(want_r.button), 16'(got_r.button));
          check_field("event_is_press", 16'(want_r.is_press), 16'(got_r.is_press));
          check_field("debounced_levels", want_r.levels, got_r.levels);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // One input transaction; valid stays high into the next item when there is no gap
  task automatic send_item(input cmd_e c, input logic [15:0] raw, input logic [3:0] idx);
    int gap;
    gap = 0;
    while (!no_idle && $urandom_range(99) < 15) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= {4'b0, idx, raw};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    expected_results.push_back(step_buttons(c, raw, idx));
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Writes all three registers back to back; only called while idle
  task automatic set_config(input logic [7:0] lim, input logic [7:0] init,
                            input logic [7:0] nxt);
    logic [1:0] regs [3];
    logic [7:0] vals [3];
    regs = '{CFG_DEBOUNCE_LIMIT, CFG_REPEAT_INITIAL, CFG_REPEAT_NEXT};
    vals = '{lim, init, nxt};
    cfg_valid_i <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      cfg_index_i <= regs[k];
      cfg_data_i  <= vals[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (regs[k])
        CFG_DEBOUNCE_LIMIT: lim_shadow  = vals[k];
        CFG_REPEAT_INITIAL: init_shadow = vals[k];
        CFG_REPEAT_NEXT:    next_shadow = vals[k];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Reset values: everything reads pressed, counters start at zero
  task automatic test_reset_state();
    send_item(CMD_SAMPLE, 16'h0000, 4'h0);   // held pressed, repeat wraps to 255
    send_item(CMD_SAMPLE, 16'h0000, 4'hf);
    send_item(CMD_SAMPLE, 16'hffff, 4'h0);   // release only starts counting
    send_item(CMD_READ_PRS, 16'hffff, 4'h0);
    send_item(CMD_NEXT_EVT, 16'h0000, 4'hf); // nothing pending yet
    send_item(CMD_CLR_FLAGS, 16'hffff, 4'hf);
    drain();
  endtask

  // Zero limit, repeat_next of zero: quick acceptance and reload wrap
  task automatic test_fast_debounce();
    set_config(8'd0, 8'd1, 8'd0);
    send_item(CMD_SAMPLE, 16'hffff, 4'h0);
    send_item(CMD_SAMPLE, 16'hffff, 4'h0);   // release of every button accepted
    send_item(CMD_NEXT_EVT, 16'h0000, 4'h0);
    send_item(CMD_NEXT_EVT, 16'h0000, 4'h0);
    send_item(CMD_SAMPLE, 16'h0000, 4'h0);
    send_item(CMD_SAMPLE, 16'h0000, 4'h0);   // press accepted
    send_item(CMD_SAMPLE, 16'h0000, 4'h0);   // repeat hits zero, reloads 0
    send_item(CMD_SAMPLE, 16'h5555, 4'h0);   // next decrement wraps
    send_item(CMD_READ_PRS, 16'h0000, 4'h0);
    send_item(CMD_READ_PRS, 16'h0000, 4'hf);
    send_item(CMD_NEXT_EVT, 16'h0000, 4'h0);
    send_item(CMD_CLR_FLAGS, 16'h0000, 4'h0);
    send_item(CMD_NEXT_EVT, 16'h0000, 4'h0); // cleared, nothing found
    drain();
  endtask

  // Limit of 255: the count wraps and never accepts
  task automatic test_stuck_limit();
    set_config(8'd255, 8'd255, 8'd255);
    send_item(CMD_SAMPLE, 16'ha5a5, 4'h0);
    send_item(CMD_SAMPLE, 16'ha5a5, 4'h0);
    send_item(CMD_SAMPLE, 16'h5a5a, 4'h0);
    send_item(CMD_READ_PRS, 16'hffff, 4'h5);
    drain();
  endtask

  // Mostly held patterns long enough to pass the debounce, with glitches and commands mixed in
  task automatic test_random_phase(input int lim, input int init, input int nxt,
                                   input int n_items, input bit calm);
    logic [15:0] pattern;
    logic [15:0] raw;
    int          hold_left;
    int          r;
    set_config(8'(lim), 8'(init), 8'(nxt));
    no_idle   = calm;
    pattern   = 16'($urandom);
    hold_left = 0;
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(99);
      if (r < 65) begin
        if (hold_left == 0) begin
          pattern   = $urandom_range(1) ? 16'($urandom) : pattern ^ 16'($urandom & $urandom);
          hold_left = ($urandom_range(9) < 7) ? $urandom_range(lim + 10, lim + 2)
                                              : $urandom_range(lim + 10, 1);
        end
        raw = pattern;
        if ($urandom_range(9) == 0) raw = raw ^ 16'($urandom & $urandom & $urandom);
        hold_left--;
        send_item(CMD_SAMPLE, raw, 4'($urandom));
      end else if (r < 80) begin
        send_item(CMD_READ_PRS, 16'($urandom), 4'($urandom));
      end else if (r < 95) begin
        send_item(CMD_NEXT_EVT, 16'($urandom), 4'($urandom));
      end else if (r < 97) begin
        send_item(CMD_CLR_FLAGS, 16'($urandom), 4'($urandom));
      end else begin
        send_item(CMD_SAMPLE, 16'($urandom), 4'($urandom));
      end
    end
    drain();
    no_idle = 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_stall();
    set_config(8'd1, 8'd3, 8'd2);
    no_idle  = 1'b1;
    hold_req = 1'b1;
    for (int k = 0; k < 80; k++) begin
      if (k % 5 == 4)
        send_item(CMD_NEXT_EVT, 16'($urandom), 4'($urandom));
      else
        send_item(CMD_SAMPLE, (k < 40) ? 16'h00ff : 16'hff00, 4'($urandom));
    end
    drain();
    no_idle = 1'b0;
  endtask

  initial begin
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = CMD_SAMPLE;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_DEBOUNCE_LIMIT;
    cfg_data_i   = 8'd0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    errors       = 0;
    quiet_cycles = 0;
    btn_stable   = '0;
    btn_pressed  = '0;
    btn_changed  = '0;
    for (int i = 0; i < 16; i++) begin
      btn_debounce[i] = 8'd0;
      btn_repeat[i]   = 8'd0;
    end
    lim_shadow  = DEBOUNCE_LIMIT_RST;
    init_shadow = REPEAT_INITIAL_RST;
    next_shadow = REPEAT_NEXT_RST;

    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_fast_debounce();
    test_stuck_limit();
    test_random_phase(0, 1, 1, 200, 1'b0);
    test_random_phase(2, 5, 3, 200, 1'b1);       // stretch with no idling
    test_random_phase(254, 255, 255, 400, 1'b0); // top of the legal limit range
    test_random_phase(255, 0, 0, 150, 1'b0);     // wrapping count and reload
    test_random_phase(1, 2, 1, 300, 1'b0);
    test_random_phase($urandom_range(6, 0), $urandom_range(12, 1), $urandom_range(12, 1),
                      200, 1'b0);
    test_output_stall();

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
